// ----- design/rmbk_pkg.sv -----
// ----------------------------------------------------------------------------
// rmbk_pkg: shared types and constants of the rolling-mean background key
// Pixel and key word layouts, register indexes, reset values and the
// reciprocal table used to divide a channel sum by the number of frames held.
// ----------------------------------------------------------------------------
package rmbk_pkg;

    // Default sizing of the frame store.
    localparam int MAX_PIXELS_DEFAULT     = 65536;
    localparam int HISTORY_FRAMES_DEFAULT = 10;

    // Channel sums wrap at twelve bits per channel.
    localparam int SUM_W = 12;

    // Reciprocal scaling: floor(x * RECIP(n) >> RECIP_SHIFT) equals floor(x / n)
    // for every twelve-bit x and every n up to sixteen.
    localparam int RECIP_SHIFT = 17;
    localparam int RECIP_W     = 18;
    localparam int RECIP_IDX_W = 5;

    // Configuration port.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 17;
    localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_PIXELS = 2'd1;

    localparam logic [7:0]            THRESHOLD_RESET    = 8'd15;
    localparam logic [CFG_DATA_W-1:0] FRAME_PIXELS_RESET = 17'd65536;

    // Output queue depth; every pixel in flight holds one of its places.
    localparam int OUT_DEPTH = 8;
    localparam int OUT_PTR_W = 3;

    // Incoming pixel word.
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pix_t;

    // Outgoing key word.
    typedef struct packed {
        logic [7:0] out_blue;
        logic [7:0] out_green;
        logic [7:0] out_red;
        logic       is_foreground;
        logic       frame_end;
    } key_t;

    // Rounded-up reciprocal of n scaled by two to the RECIP_SHIFT.
    function automatic logic [RECIP_W-1:0] recip(input logic [RECIP_IDX_W-1:0] n);
        logic [RECIP_W-1:0] r;
        case (n)
            5'd1:    r = 18'd131072;
            5'd2:    r = 18'd65536;
            5'd3:    r = 18'd43691;
            5'd4:    r = 18'd32768;
            5'd5:    r = 18'd26215;
            5'd6:    r = 18'd21846;
            5'd7:    r = 18'd18725;
            5'd8:    r = 18'd16384;
            5'd9:    r = 18'd14564;
            5'd10:   r = 18'd13108;
            5'd11:   r = 18'd11916;
            5'd12:   r = 18'd10923;
            5'd13:   r = 18'd10083;
            5'd14:   r = 18'd9363;
            5'd15:   r = 18'd8739;
            5'd16:   r = 18'd8192;
            default: r = 18'd0;
        endcase
        return r;
    endfunction

endpackage

// ----- design/rolling_mean_background_key.sv -----
// ----------------------------------------------------------------------------
// rolling_mean_background_key: background keying against a rolling mean
// Compares each pixel with the mean of the same position over the held frames
// and zeroes it when it matches the background in any channel.
// ----------------------------------------------------------------------------
// The block takes one pixel word per clock while pix_stall is low and returns
// one key word per pixel, in order; a key word is taken at an edge where
// key_stall is low. The rate is set by the read-modify-write of the
// per-position sum memory: it is read when a pixel is taken, updated and
// written in the next cycle, and a one-entry bypass covers the pixel that
// follows at the same position. The mean is formed by a reciprocal multiply
// and a remainder check over the next two stages. An eight-word output queue
// holds finished keys; the pixel stall rises only when eight pixels are in
// flight or queued. The frame and sum memories are not cleared after reset:
// the first frame seeds the sums, so no clearing pass is needed and a pixel
// is taken right after reset. The user must write configuration only while
// no pixel is in flight; the block itself does not enforce it.
module rolling_mean_background_key #(
    parameter int MAX_PIXELS     = rmbk_pkg::MAX_PIXELS_DEFAULT,
    parameter int HISTORY_FRAMES = rmbk_pkg::HISTORY_FRAMES_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Pixel channel
    input  logic                             pix_valid,
    output logic                             pix_stall,
    input  rmbk_pkg::pix_t                   pix,
    // Key channel
    output logic                             key_valid,
    input  logic                             key_stall,
    output rmbk_pkg::key_t                   key,
    // Configuration channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rmbk_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rmbk_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import rmbk_pkg::*;

    localparam int POS_W      = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int SZ_W       = (POS_W + 1 > CFG_DATA_W) ? POS_W + 1 : CFG_DATA_W;
    localparam int HIST_DEPTH = HISTORY_FRAMES * MAX_PIXELS;
    localparam int HA_W       = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int FH_W       = $clog2(HISTORY_FRAMES + 1);
    localparam int CNT_W      = $clog2(OUT_DEPTH + 1);
    localparam int PROD_W     = SUM_W + RECIP_W;
    localparam int QN_W       = SUM_W + FH_W;

    typedef logic [2:0][7:0]       chan_t;
    typedef logic [2:0][SUM_W-1:0] sums_t;

    // Configuration registers
    logic [7:0]            threshold_reg;
    logic [CFG_DATA_W-1:0] frame_pixels_reg;

    // Frame position state
    logic [POS_W-1:0] pos_reg;
    logic [HA_W-1:0]  base_reg;
    logic [HA_W-1:0]  haddr_reg;
    logic [FH_W-1:0]  fh_reg;
    logic [POS_W-1:0] pos_next;
    logic [HA_W-1:0]  base_next;
    logic [HA_W-1:0]  haddr_next;
    logic [FH_W-1:0]  fh_next;

    // Memories
    sums_t sums_mem [MAX_PIXELS];
    chan_t hist_mem [HIST_DEPTH];

    // Credit counter and output queue
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic [CNT_W-1:0]     fifo_cnt_reg;
    logic [CNT_W-1:0]     fifo_cnt_next;
    logic [OUT_PTR_W-1:0] wr_ptr_reg;
    logic [OUT_PTR_W-1:0] rd_ptr_reg;
    key_t                 fifo_mem [OUT_DEPTH];

    // Stage 1: memory data and update
    logic             s1_valid_reg;
    chan_t            s1_px_reg;
    logic [POS_W-1:0] s1_pos_reg;
    logic [HA_W-1:0]  s1_haddr_reg;
    logic [FH_W-1:0]  s1_fh_reg;
    logic             s1_last_reg;
    sums_t            s1_sum_raw_reg;
    chan_t            s1_old_raw_reg;

    // Bypass of the write made at the previous edge
    logic             wr_valid_reg;
    logic [POS_W-1:0] wr_pos_reg;
    logic [HA_W-1:0]  wr_haddr_reg;
    sums_t            wr_sum_reg;
    chan_t            wr_px_reg;

    // Stage 2: reciprocal multiply
    logic            s2_valid_reg;
    chan_t           s2_px_reg;
    logic [FH_W-1:0] s2_fh_reg;
    logic            s2_last_reg;
    sums_t           s2_cur_reg;

    // Stage 3: remainder
    logic            s3_valid_reg;
    chan_t           s3_px_reg;
    logic [FH_W-1:0] s3_fh_reg;
    logic            s3_last_reg;
    sums_t           s3_cur_reg;
    sums_t           s3_q_reg;

    // Stage 4: rounding and classification
    logic                       s4_valid_reg;
    chan_t                      s4_px_reg;
    logic [FH_W-1:0]            s4_fh_reg;
    logic                       s4_last_reg;
    sums_t                      s4_q_reg;
    logic [2:0][FH_W-1:0]       s4_r_reg;

    logic pix_acc;
    logic key_acc;

    // Stage 0 combinational
    logic [SZ_W-1:0] fp_ext;
    logic [SZ_W-1:0] size_eff;
    logic [SZ_W-1:0] pos_inc;
    logic            s0_last;
    logic [HA_W:0]   base_sum;
    chan_t           px_in;

    // Stage 1 combinational
    sums_t s1_cur;
    chan_t s1_old;
    sums_t s1_new;

    // Stage 2 and 3 combinational
    sums_t                s2_q;
    logic [2:0][FH_W-1:0] s3_r;

    // Stage 4 combinational
    logic [FH_W:0]  s4_two_r [3];
    logic [7:0]     s4_mean  [3];
    logic [7:0]     s4_diff  [3];
    logic           s4_bg;
    key_t           s4_key;

    // Handshakes
    assign cfg_ready = 1'b1;
    assign pix_stall = (cnt_reg == CNT_W'(OUT_DEPTH));
    assign pix_acc   = pix_valid && !pix_stall;
    assign key_valid = (fifo_cnt_reg != '0);
    assign key_acc   = key_valid && !key_stall;
    assign key       = fifo_mem[rd_ptr_reg];

    assign px_in = {pix.red, pix.green, pix.blue};

    // Frame size with out-of-range values folded in, and end of frame.
    always_comb
    begin
        fp_ext = SZ_W'(frame_pixels_reg);
        if (fp_ext == '0)
        begin
            size_eff = SZ_W'(1);
        end
        else if (fp_ext > SZ_W'(MAX_PIXELS))
        begin
            size_eff = SZ_W'(MAX_PIXELS);
        end
        else
        begin
            size_eff = fp_ext;
        end
        pos_inc = SZ_W'(pos_reg) + SZ_W'(1);
        s0_last = (pos_inc >= size_eff);
    end

    // Next position, ring base and frame count.
    always_comb
    begin
        base_sum   = {1'b0, base_reg} + (HA_W + 1)'(MAX_PIXELS);
        pos_next   = pos_reg;
        base_next  = base_reg;
        haddr_next = haddr_reg;
        fh_next    = fh_reg;
        if (pix_acc)
        begin
            if (s0_last)
            begin
                pos_next = '0;
                if (base_sum >= (HA_W + 1)'(HIST_DEPTH))
                begin
                    base_next = '0;
                end
                else
                begin
                    base_next = base_sum[HA_W-1:0];
                end
                haddr_next = base_next;
                if (fh_reg < FH_W'(HISTORY_FRAMES))
                begin
                    fh_next = fh_reg + FH_W'(1);
                end
            end
            else
            begin
                pos_next   = pos_inc[POS_W-1:0];
                haddr_next = haddr_reg + HA_W'(1);
            end
        end
    end

    // Credit and queue counts.
    always_comb
    begin
        cnt_next      = cnt_reg + CNT_W'(pix_acc) - CNT_W'(key_acc);
        fifo_cnt_next = fifo_cnt_reg + CNT_W'(s4_valid_reg) - CNT_W'(key_acc);
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg    <= THRESHOLD_RESET;
            frame_pixels_reg <= FRAME_PIXELS_RESET;
            pos_reg          <= '0;
            base_reg         <= '0;
            haddr_reg        <= '0;
            fh_reg           <= '0;
            cnt_reg          <= '0;
            fifo_cnt_reg     <= '0;
            wr_ptr_reg       <= '0;
            rd_ptr_reg       <= '0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            s4_valid_reg     <= 1'b0;
            wr_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_THRESHOLD)
                begin
                    threshold_reg <= cfg_data[7:0];
                end
                else if (cfg_index == CFG_FRAME_PIXELS)
                begin
                    frame_pixels_reg <= cfg_data;
                end
            end
            pos_reg      <= pos_next;
            base_reg     <= base_next;
            haddr_reg    <= haddr_next;
            fh_reg       <= fh_next;
            cnt_reg      <= cnt_next;
            fifo_cnt_reg <= fifo_cnt_next;
            if (s4_valid_reg)
            begin
                wr_ptr_reg <= wr_ptr_reg + OUT_PTR_W'(1);
            end
            if (key_acc)
            begin
                rd_ptr_reg <= rd_ptr_reg + OUT_PTR_W'(1);
            end
            s1_valid_reg <= pix_acc;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            wr_valid_reg <= s1_valid_reg;
        end
    end

    // Memory reads at the current position, and writes from stage 1.
    always_ff @(posedge clk)
    begin
        s1_sum_raw_reg <= sums_mem[pos_reg];
        s1_old_raw_reg <= hist_mem[haddr_reg];
        if (s1_valid_reg)
        begin
            sums_mem[s1_pos_reg]  <= s1_new;
            hist_mem[s1_haddr_reg] <= s1_px_reg;
        end
    end

    // Stage 1: take the bypass when the previous write hit the same entry,
    // then drop the evicted pixel and add the new one.
    always_comb
    begin
        if (wr_valid_reg && (wr_pos_reg == s1_pos_reg))
        begin
            s1_cur = wr_sum_reg;
        end
        else
        begin
            s1_cur = s1_sum_raw_reg;
        end
        if (wr_valid_reg && (wr_haddr_reg == s1_haddr_reg))
        begin
            s1_old = wr_px_reg;
        end
        else
        begin
            s1_old = s1_old_raw_reg;
        end
        // The first frame seeds the sums.
        if (s1_fh_reg == '0)
        begin
            s1_cur = '0;
        end
        for (int c = 0; c < 3; c++)
        begin
            s1_new[c] = s1_cur[c] + SUM_W'(s1_px_reg[c]);
            if (s1_fh_reg >= FH_W'(HISTORY_FRAMES))
            begin
                s1_new[c] = s1_new[c] - SUM_W'(s1_old[c]);
            end
        end
    end

    // Stage 2: quotient by reciprocal multiply.
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            logic [PROD_W-1:0] prod;
            prod = PROD_W'(s2_cur_reg[c]) * PROD_W'(recip(RECIP_IDX_W'(s2_fh_reg)));
            s2_q[c] = prod[RECIP_SHIFT +: SUM_W];
        end
    end

    // Stage 3: remainder of the division.
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            logic [QN_W-1:0]  qn;
            logic [SUM_W-1:0] rem;
            qn      = QN_W'(s3_q_reg[c]) * QN_W'(s3_fh_reg);
            rem     = s3_cur_reg[c] - qn[SUM_W-1:0];
            s3_r[c] = rem[FH_W-1:0];
        end
    end

    // Stage 4: round half to even, clamp, compare with the threshold.
    always_comb
    begin
        s4_bg = 1'b0;
        for (int c = 0; c < 3; c++)
        begin
            logic          up;
            logic [SUM_W:0] m;
            s4_two_r[c] = {s4_r_reg[c], 1'b0};
            up = (s4_two_r[c] > (FH_W + 1)'(s4_fh_reg))
                 || ((s4_two_r[c] == (FH_W + 1)'(s4_fh_reg)) && s4_q_reg[c][0]);
            m  = (SUM_W + 1)'(s4_q_reg[c]) + (SUM_W + 1)'(up);
            if (s4_fh_reg == '0)
            begin
                s4_mean[c] = s4_px_reg[c];
            end
            else if (m > (SUM_W + 1)'(255))
            begin
                s4_mean[c] = 8'd255;
            end
            else
            begin
                s4_mean[c] = m[7:0];
            end
            if (s4_px_reg[c] > s4_mean[c])
            begin
                s4_diff[c] = s4_px_reg[c] - s4_mean[c];
            end
            else
            begin
                s4_diff[c] = s4_mean[c] - s4_px_reg[c];
            end
            if (s4_diff[c] < threshold_reg)
            begin
                s4_bg = 1'b1;
            end
        end
        s4_key.out_blue      = s4_bg ? 8'd0 : s4_px_reg[0];
        s4_key.out_green     = s4_bg ? 8'd0 : s4_px_reg[1];
        s4_key.out_red       = s4_bg ? 8'd0 : s4_px_reg[2];
        s4_key.is_foreground = !s4_bg;
        s4_key.frame_end     = s4_last_reg;
    end

    // Pipeline payload and output queue.
    always_ff @(posedge clk)
    begin
        s1_px_reg    <= px_in;
        s1_pos_reg   <= pos_reg;
        s1_haddr_reg <= haddr_reg;
        s1_fh_reg    <= fh_reg;
        s1_last_reg  <= s0_last;

        wr_pos_reg   <= s1_pos_reg;
        wr_haddr_reg <= s1_haddr_reg;
        wr_sum_reg   <= s1_new;
        wr_px_reg    <= s1_px_reg;

        s2_px_reg    <= s1_px_reg;
        s2_fh_reg    <= s1_fh_reg;
        s2_last_reg  <= s1_last_reg;
        s2_cur_reg   <= s1_cur;

        s3_px_reg    <= s2_px_reg;
        s3_fh_reg    <= s2_fh_reg;
        s3_last_reg  <= s2_last_reg;
        s3_cur_reg   <= s2_cur_reg;
        s3_q_reg     <= s2_q;

        s4_px_reg    <= s3_px_reg;
        s4_fh_reg    <= s3_fh_reg;
        s4_last_reg  <= s3_last_reg;
        s4_q_reg     <= s3_q_reg;
        s4_r_reg     <= s3_r;

        if (s4_valid_reg)
        begin
            fifo_mem[wr_ptr_reg] <= s4_key;
        end
    end

`ifndef ASSERT_OFF
    // Credits cover every word in the stages and in the queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == CNT_W'(fifo_cnt_reg) + CNT_W'(s1_valid_reg) + CNT_W'(s2_valid_reg)
                   + CNT_W'(s3_valid_reg) + CNT_W'(s4_valid_reg))
        else $error("credit count does not match words in flight");

    // The queue is never written while full.
    assert property (@(posedge clk) disable iff (!rst_n)
        s4_valid_reg |-> (fifo_cnt_reg < CNT_W'(OUT_DEPTH)) || key_acc)
        else $error("output queue overflow");

    // A taken pixel always reaches the classification stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        pix_acc |-> ##4 s4_valid_reg)
        else $error("pixel lost in the pipeline");

    // The last pixel of a frame restarts the position at zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        pix_acc && s0_last |=> (pos_reg == '0) && (haddr_reg == base_reg))
        else $error("frame position not restarted");

    // The frame count never runs past the ring length.
    assert property (@(posedge clk) disable iff (!rst_n)
        fh_reg <= FH_W'(HISTORY_FRAMES))
        else $error("frame count beyond ring length");
`endif

endmodule

// ----- sim/tb_rolling_mean_background_key.sv -----
// ----------------------------------------------------------------------------
// tb_rolling_mean_background_key: self-checking bench for the background key
// Streams pixel words through the block while both handshakes idle at random.
// A scoreboard keeps its own rolling-mean frame store, predicts every key word
// and compares each returned word, field by field, in order of arrival.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_rolling_mean_background_key;
    import rmbk_pkg::*;

    localparam int MAX_PIX     = MAX_PIXELS_DEFAULT;
    localparam int HIST        = HISTORY_FRAMES_DEFAULT;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int TAIL_CYCLES = 32;

    // Register indexes that the block does not decode.
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef struct {
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } reg_write_t;

    // Predicts key words from the rolling-mean store and checks returned ones.
    class key_scoreboard;
        bit [7:0]    threshold;
        bit [16:0]   frame_pixels;
        int unsigned position;
        int unsigned frames_held;
        int unsigned ring_slot;
        bit [23:0]   history [HIST][MAX_PIX];
        bit [11:0]   sums [MAX_PIX][3];
        key_t        expected_keys [$];
        int          errors;

        function new();
            threshold    = THRESHOLD_RESET;
            frame_pixels = FRAME_PIXELS_RESET;
            position     = 0;
            frames_held  = 0;
            ring_slot    = 0;
            errors       = 0;
        endfunction

        function void write_register(logic [CFG_INDEX_W-1:0] index,
                                     logic [CFG_DATA_W-1:0] data);
            case (index)
                CFG_THRESHOLD:    threshold = data[7:0];
                CFG_FRAME_PIXELS: frame_pixels = data;
                default: ;
            endcase
        endfunction

        // Mean of a channel sum over n frames, with ties going to the even value.
        function int unsigned rounded_mean(int unsigned sum, int unsigned n);
            int unsigned q;
            int unsigned r;
            q = sum / n;
            r = sum % n;
            if (2 * r > n || (2 * r == n && q % 2 == 1))
                q++;
            return (q > 255) ? 255 : q;
        endfunction

        function void note_pixel(pix_t p);
            int unsigned size;
            int unsigned pos;
            int unsigned mean;
            int unsigned diff;
            int unsigned sum;
            bit [7:0]    chan [3];
            bit [23:0]   evicted;
            bit          background;
            key_t        k;
            chan[0] = p.blue;
            chan[1] = p.green;
            chan[2] = p.red;
            size = frame_pixels;
            if (size == 0)
                size = 1;
            if (size > MAX_PIX)
                size = MAX_PIX;
            pos = (position >= MAX_PIX) ? 0 : position;

            // Any channel close to its mean marks the pixel as background.
            background = 1'b0;
            for (int c = 0; c < 3; c++)
            begin
                mean = (frames_held == 0) ? chan[c] : rounded_mean(sums[pos][c], frames_held);
                diff = (chan[c] > mean) ? chan[c] - mean : mean - chan[c];
                if (diff < threshold)
                    background = 1'b1;
            end
            k.out_blue      = background ? 8'd0 : chan[0];
            k.out_green     = background ? 8'd0 : chan[1];
            k.out_red       = background ? 8'd0 : chan[2];
            k.is_foreground = !background;
            k.frame_end     = (pos + 1 >= size);

            // Drop the evicted frame's pixel from the sums and add the new one.
            evicted = history[ring_slot][pos];
            for (int c = 0; c < 3; c++)
            begin
                sum = sums[pos][c];
                if (frames_held >= HIST)
                    sum -= evicted[8 * c +: 8];
                sum += chan[c];
                sums[pos][c] = 12'(sum);
            end
            history[ring_slot][pos] = {chan[2], chan[1], chan[0]};

            if (k.frame_end)
            begin
                position = 0;
                if (frames_held < HIST)
                    frames_held++;
                ring_slot = (ring_slot + 1) % HIST;
            end
            else
            begin
                position = pos + 1;
            end
            expected_keys = {expected_keys, k};
        endfunction

        function int pending();
            return expected_keys.size();
        endfunction

        function void report(string field, logic [7:0] want, logic [7:0] got);
            errors++;
            $display("%0t: key %s mismatch: expected %h, actual %h",
                     $time, field, want, got);
        endfunction

        function void check_key(key_t k);
            key_t e;
            if (expected_keys.size() == 0)
            begin
                errors++;
                $display("%0t: key word mismatch: expected none, actual %h", $time, k);
                return;
            end
            e = expected_keys.pop_front();
            if (k.out_blue !== e.out_blue)
                report("out_blue", e.out_blue, k.out_blue);
            if (k.out_green !== e.out_green)
                report("out_green", e.out_green, k.out_green);
            if (k.out_red !== e.out_red)
                report("out_red", e.out_red, k.out_red);
            if (k.is_foreground !== e.is_foreground)
                report("is_foreground", 8'(e.is_foreground), 8'(k.is_foreground));
            if (k.frame_end !== e.frame_end)
                report("frame_end", 8'(e.frame_end), 8'(k.frame_end));
        endfunction
    endclass

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   pix_valid = 1'b0;
    logic                   pix_stall;
    pix_t                   pix       = '0;
    logic                   key_valid;
    logic                   key_stall = 1'b0;
    key_t                   key;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    key_scoreboard sb;
    reg_write_t    reg_writes [$];
    int            pix_idle_pct  = 32;
    int            key_stall_pct = 32;
    int unsigned   cycles        = 0;

    rolling_mean_background_key dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix       (pix),
        .key_valid (key_valid),
        .key_stall (key_stall),
        .key       (key),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock: 4 ns period.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Key side: check each accepted word and stall at random.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (key_valid && !key_stall)
                sb.check_key(key);
            key_stall <= ($urandom_range(99) < key_stall_pct);
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: run timed out", $time);
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [7:0] jitter(int base, int spread);
        int v;
        v = base + int'($urandom_range(2 * spread)) - spread;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return v[7:0];
    endfunction

    // Mostly a fixed scene with noise around it, sometimes a random pixel.
    function automatic pix_t scene_pixel(int unsigned pos);
        int unsigned pick;
        int          spread;
        pix_t        p;
        pick = $urandom_range(99);
        if (pick < 15)
        begin
            p.blue  = 8'($urandom_range(255));
            p.green = 8'($urandom_range(255));
            p.red   = 8'($urandom_range(255));
        end
        else
        begin
            spread  = (pick < 75) ? 12 : 40;
            p.blue  = jitter((pos * 53 + 11) % 256, spread);
            p.green = jitter((pos * 29 + 97) % 256, spread);
            p.red   = jitter((pos * 71 + 193) % 256, spread);
        end
        return p;
    endfunction

    task automatic send_pixel(input pix_t p);
        while ($urandom_range(99) < pix_idle_pct)
        begin
            pix_valid <= 1'b0;
            @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix       <= p;
        do
            @(posedge clk);
        while (pix_stall);
        sb.note_pixel(p);
    endtask

    task automatic send_pixels(input int n);
        repeat (n)
            send_pixel(scene_pixel(sb.position));
    endtask

    // Sends pixels until n frames have ended.
    task automatic send_frames(input int n);
        repeat (n)
        begin
            do
                send_pixel(scene_pixel(sb.position));
            while (sb.position != 0);
        end
    endtask

    // Holds the pixel side until every expected key word has come back.
    task automatic drain();
        pix_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    task automatic queue_write(input logic [CFG_INDEX_W-1:0] index,
                               input logic [CFG_DATA_W-1:0] data);
        reg_write_t w;
        w.index    = index;
        w.data     = data;
        reg_writes = {reg_writes, w};
    endtask

    // Writes the queued registers once the block has gone idle.
    task automatic write_registers();
        reg_write_t w;
        drain();
        if (reg_writes.size() != 0)
        begin
            cfg_valid <= 1'b1;
            while (reg_writes.size() != 0)
            begin
                w = reg_writes.pop_front();
                cfg_index <= w.index;
                cfg_data  <= w.data;
                do
                    @(posedge clk);
                while (!cfg_ready);
                sb.write_register(w.index, w.data);
            end
            cfg_valid <= 1'b0;
        end
    endtask

    initial
    begin
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Empty ring at the reset threshold: every pixel keys out.
        send_pixel('{8'h00, 8'h00, 8'h00});
        send_pixel('{8'hFF, 8'hFF, 8'hFF});
        send_pixel('{8'h00, 8'hFF, 8'h80});

        // Zero threshold: every pixel passes through.
        queue_write(CFG_THRESHOLD, 17'd0);
        write_registers();
        send_pixel('{8'h00, 8'h00, 8'h00});
        send_pixel('{8'hFF, 8'hFF, 8'hFF});
        send_pixel('{8'h12, 8'h34, 8'h56});
        send_pixel('{8'hFF, 8'h00, 8'hFF});
        send_pixel('{8'h01, 8'h80, 8'hFE});

        // Largest threshold, then the smallest nonzero one.
        queue_write(CFG_THRESHOLD, 17'd255);
        write_registers();
        send_pixel('{8'hFF, 8'h00, 8'h7F});
        send_pixel('{8'h80, 8'h80, 8'h80});
        queue_write(CFG_THRESHOLD, 17'd1);
        write_registers();
        send_pixel('{8'h55, 8'hAA, 8'h55});

        // An oversized frame acts as the full store, so the frame runs on.
        queue_write(CFG_FRAME_PIXELS, 17'h1FFFF);
        queue_write(CFG_THRESHOLD, 17'd15);
        write_registers();
        send_pixels(20);

        // Small frames: close the seed frame, run five frames at full speed on
        // both sides, then run past the ring length so frames get evicted.
        queue_write(CFG_FRAME_PIXELS, 17'd64);
        write_registers();
        send_frames(1);
        pix_idle_pct  = 0;
        key_stall_pct = 0;
        send_frames(5);
        pix_idle_pct  = 32;
        key_stall_pct = 32;
        send_pixels(20);
        drain();
        send_frames(1);
        queue_write(CFG_THRESHOLD, 17'($urandom_range(16, 60)));
        write_registers();
        send_frames(8);

        // Shrinking the frame past the current position ends the frame at once.
        send_pixels(50);
        queue_write(CFG_FRAME_PIXELS, 17'd40);
        queue_write(CFG_THRESHOLD, 17'd255);
        write_registers();
        send_frames(3);
        queue_write(CFG_THRESHOLD, 17'd0);
        write_registers();
        send_frames(1);

        // Shrinking ahead of the current position just shortens the frame.
        queue_write(CFG_THRESHOLD, 17'($urandom_range(1, 60)));
        write_registers();
        send_pixels(5);
        queue_write(CFG_FRAME_PIXELS, 17'd16);
        write_registers();
        send_frames(14);

        // Undecoded indexes are ignored; one-pixel frames keep hitting one sum.
        queue_write(CFG_SPARE_A, 17'h1FFFF);
        queue_write(CFG_SPARE_B, 17'd0);
        queue_write(CFG_FRAME_PIXELS, 17'd1);
        queue_write(CFG_THRESHOLD, 17'd8);
        write_registers();
        send_frames(30);

        // A zero frame size acts as one. A full-white history against black
        // differs by the whole range, and the next mean lands on a tie.
        queue_write(CFG_FRAME_PIXELS, 17'd0);
        queue_write(CFG_THRESHOLD, 17'd255);
        write_registers();
        repeat (HIST)
            send_pixel('{8'hFF, 8'hFF, 8'hFF});
        send_pixel('{8'h00, 8'h00, 8'h00});
        send_pixel('{8'h00, 8'h00, 8'h00});
        queue_write(CFG_THRESHOLD, 17'($urandom_range(1, 60)));
        write_registers();
        send_frames(20);

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
